FILE: rtl/core/lsolve3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsolve3_pkg;

   // default fraction bits of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // divider: quotient bits produced and bits resolved per pipeline stage
   localparam int DIV_BITS = 33;
   localparam int DIV_STEP = 3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [31:0] a_00;
      logic signed [31:0] a_01;
      logic signed [31:0] a_02;
      logic signed [31:0] a_10;
      logic signed [31:0] a_11;
      logic signed [31:0] a_12;
      logic signed [31:0] a_20;
      logic signed [31:0] a_21;
      logic signed [31:0] a_22;
      logic signed [31:0] rhs_0;
      logic signed [31:0] rhs_1;
      logic signed [31:0] rhs_2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sol_0;
      logic signed [31:0] sol_1;
      logic signed [31:0] sol_2;
      logic [1:0]         pivot_first;
      logic [1:0]         pivot_second;
      logic [1:0]         status;
   } rsp_type;

   // working set of one request as it moves down the pipeline
   typedef struct packed {
      logic [2:0][2:0][31:0] m;     // matrix, [row][column]
      logic [2:0][31:0]      r;     // updated right-hand side
      logic [2:0][31:0]      b;     // original right-hand side
      logic [2:0][31:0]      s;     // row scales (magnitudes)
      logic [2:0][31:0]      x;     // solution
      logic [5:0][63:0]      pr;    // products / scratch
      logic [5:0]            pn;    // product signs
      logic [1:0]            piv0;
      logic [1:0]            piv1;
      logic                  sing;
      logic                  ovf;
   } ctx_type;

   // magnitude of a two's complement word; -2^31 maps to 2^31
   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/linear_solve_3x3_scaled_pivot.sv
// 3x3 linear solver, Gaussian elimination with scaled partial pivoting.
// Request channel (req_valid / req_ready / req_data) takes A and b in signed
// Q format; response channel (rsp_valid / rsp_ready / rsp_data) returns x,
// the two pivot rows and a status (solved, singular, overflow).
// Throughput: one request per cycle while req_ready is high. The datapath is
// a fixed pipeline with five pipelined dividers (3 quotient bits per stage)
// on the critical chain: step 0 multipliers, step 1 multiplier, then x2, x1, x0.
// The pipeline ends in a two-entry output buffer; req_ready is low only
// while both entries hold unread responses, so one waiting response does not
// stop the flow; once both are full the whole pipeline holds until the receiver
// takes a response. Nothing is dropped or repeated across a stall.
// Reset (synchronous, active high) clears all valid bits and the buffer;
// the block is ready in the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module linear_solve_3x3_scaled_pivot #(
   parameter int FRAC_BITS = lsolve3_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lsolve3_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lsolve3_pkg::rsp_type rsp_data
);

   localparam int CTX_W = $bits(lsolve3_pkg::ctx_type);

   // truncated product magnitude |a|*|b| >> FRAC_BITS
   function automatic logic [63:0] mulq_mag(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, lsolve3_pkg::mag32(a)} * {32'd0, lsolve3_pkg::mag32(b)};
      return p >> FRAC_BITS;
   endfunction

   // {overflow, value}
   function automatic logic [32:0] sat64(input logic [63:0] v);
      if (v[63:31] == {33{v[63]}}) return {1'b0, v[31:0]};
      else if (v[63])              return {1'b1, 32'h8000_0000};
      else                         return {1'b1, 32'h7fff_ffff};
   endfunction

   // a - (signed product), saturated
   function automatic logic [32:0] upd(input logic [31:0] a, input logic [63:0] p,
                                       input logic neg);
      logic [63:0] ax;
      logic [63:0] d;
      ax = {{32{a[31]}}, a};
      d  = neg ? ax + p : ax - p;
      return sat64(d);
   endfunction

   lsolve3_pkg::ctx_type c1_in, c2_in, c3_in, c4_in, c5_in, c6_in, c7_in, c8_in;
   lsolve3_pkg::ctx_type c9_in, c10_in, c11_in, c12_in, c13_in, c14_in, c15_in, c16_in;
   lsolve3_pkg::ctx_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff, c8_ff;
   lsolve3_pkg::ctx_type c9_ff, c10_ff, c11_ff, c12_ff, c13_ff, c14_ff, c15_ff, c16_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff;

   logic adv;

   logic [1:0][31:0]     da_num, da_den, da_quot;
   logic [1:0]           da_ovf;
   lsolve3_pkg::ctx_type da_ctx;
   logic                 da_valid;

   logic [0:0][31:0]     db_num, db_den, db_quot;
   logic [0:0]           db_ovf;
   lsolve3_pkg::ctx_type db_ctx;
   logic                 db_valid;

   logic [0:0][31:0]     dc_num, dc_den, dc_quot;
   logic [0:0]           dc_ovf;
   lsolve3_pkg::ctx_type dc_ctx;
   logic                 dc_valid;

   logic [0:0][31:0]     dd_num, dd_den, dd_quot;
   logic [0:0]           dd_ovf;
   lsolve3_pkg::ctx_type dd_ctx;
   logic                 dd_valid;

   logic [0:0][31:0]     de_num, de_den, de_quot;
   logic [0:0]           de_ovf;
   lsolve3_pkg::ctx_type de_ctx;
   logic                 de_valid;

   lsolve3_pkg::rsp_type res, head_ff, skid_ff;
   logic [1:0]           ocnt_ff, ocnt_in;
   logic                 push, pop;

   // load request, row scales, zero-row check
   always_comb begin : s1
      logic [31:0] mx;
      c1_in         = '0;
      c1_in.m[0][0] = req_data.a_00;
      c1_in.m[0][1] = req_data.a_01;
      c1_in.m[0][2] = req_data.a_02;
      c1_in.m[1][0] = req_data.a_10;
      c1_in.m[1][1] = req_data.a_11;
      c1_in.m[1][2] = req_data.a_12;
      c1_in.m[2][0] = req_data.a_20;
      c1_in.m[2][1] = req_data.a_21;
      c1_in.m[2][2] = req_data.a_22;
      c1_in.r[0]    = req_data.rhs_0;
      c1_in.r[1]    = req_data.rhs_1;
      c1_in.r[2]    = req_data.rhs_2;
      c1_in.b       = c1_in.r;
      c1_in.piv1    = 2'd1;
      for (int i = 0; i < 3; i++) begin
         mx = lsolve3_pkg::mag32(c1_in.m[i][0]);
         if (lsolve3_pkg::mag32(c1_in.m[i][1]) > mx) mx = lsolve3_pkg::mag32(c1_in.m[i][1]);
         if (lsolve3_pkg::mag32(c1_in.m[i][2]) > mx) mx = lsolve3_pkg::mag32(c1_in.m[i][2]);
         c1_in.s[i] = mx;
         if (mx == 32'd0) c1_in.sing = 1'b1;
      end
   end

   // step 0 cross products for the scaled pivot compare
   always_comb begin : s2
      logic [31:0] a0, a1, a2;
      c2_in    = c1_ff;
      a0       = lsolve3_pkg::mag32(c1_ff.m[0][0]);
      a1       = lsolve3_pkg::mag32(c1_ff.m[1][0]);
      a2       = lsolve3_pkg::mag32(c1_ff.m[2][0]);
      c2_in.pr[0] = {32'd0, a1} * {32'd0, c1_ff.s[0]};
      c2_in.pr[1] = {32'd0, a0} * {32'd0, c1_ff.s[1]};
      c2_in.pr[2] = {32'd0, a2} * {32'd0, c1_ff.s[0]};
      c2_in.pr[3] = {32'd0, a0} * {32'd0, c1_ff.s[2]};
      c2_in.pr[4] = {32'd0, a2} * {32'd0, c1_ff.s[1]};
      c2_in.pr[5] = {32'd0, a1} * {32'd0, c1_ff.s[2]};
   end

   // step 0 pivot choice (lowest row wins a tie) and row swap
   always_comb begin : s3
      logic       has;
      logic [1:0] best;
      c3_in = c2_ff;
      has   = 1'b0;
      best  = 2'd0;
      if (c2_ff.m[0][0] != 32'd0) has = 1'b1;
      if (c2_ff.m[1][0] != 32'd0 && (!has || c2_ff.pr[0] > c2_ff.pr[1])) begin
         has  = 1'b1;
         best = 2'd1;
      end
      if (c2_ff.m[2][0] != 32'd0 &&
          (!has || (best == 2'd0 ? c2_ff.pr[2] > c2_ff.pr[3]
                                 : c2_ff.pr[4] > c2_ff.pr[5]))) begin
         has  = 1'b1;
         best = 2'd2;
      end
      if (!c2_ff.sing) begin
         c3_in.piv0 = best;
         if (!has) c3_in.sing = 1'b1;
      end
      if (best == 2'd1) begin
         c3_in.m[0] = c2_ff.m[1];  c3_in.m[1] = c2_ff.m[0];
         c3_in.r[0] = c2_ff.r[1];  c3_in.r[1] = c2_ff.r[0];
         c3_in.s[0] = c2_ff.s[1];  c3_in.s[1] = c2_ff.s[0];
      end else if (best == 2'd2) begin
         c3_in.m[0] = c2_ff.m[2];  c3_in.m[2] = c2_ff.m[0];
         c3_in.r[0] = c2_ff.r[2];  c3_in.r[2] = c2_ff.r[0];
         c3_in.s[0] = c2_ff.s[2];  c3_in.s[2] = c2_ff.s[0];
      end
   end

   // step 0 multipliers for rows 1 and 2
   assign da_num = {c3_ff.m[2][0], c3_ff.m[1][0]};
   assign da_den = {c3_ff.m[0][0], c3_ff.m[0][0]};

   lsolve3_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .PAY_W(CTX_W)) u_div_a (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(v3_ff), .in_num(da_num), .in_den(da_den), .in_pay(c3_ff),
      .out_valid(da_valid), .out_quot(da_quot), .out_ovf(da_ovf), .out_pay(da_ctx)
   );

   // step 0 update products
   always_comb begin : s4
      c4_in     = da_ctx;
      c4_in.ovf = da_ctx.ovf | da_ovf[0] | da_ovf[1];
      for (int l = 0; l < 2; l++) begin
         c4_in.pr[3*l]   = mulq_mag(da_quot[l], da_ctx.m[0][1]);
         c4_in.pn[3*l]   = da_quot[l][31] ^ da_ctx.m[0][1][31];
         c4_in.pr[3*l+1] = mulq_mag(da_quot[l], da_ctx.m[0][2]);
         c4_in.pn[3*l+1] = da_quot[l][31] ^ da_ctx.m[0][2][31];
         c4_in.pr[3*l+2] = mulq_mag(da_quot[l], da_ctx.r[0]);
         c4_in.pn[3*l+2] = da_quot[l][31] ^ da_ctx.r[0][31];
      end
   end

   // step 0 eliminate
   always_comb begin : s5
      logic [32:0] u;
      c5_in = c4_ff;
      for (int l = 0; l < 2; l++) begin
         c5_in.m[l+1][0] = 32'd0;
         u = upd(c4_ff.m[l+1][1], c4_ff.pr[3*l], c4_ff.pn[3*l]);
         c5_in.m[l+1][1] = u[31:0];
         c5_in.ovf       = c5_in.ovf | u[32];
         u = upd(c4_ff.m[l+1][2], c4_ff.pr[3*l+1], c4_ff.pn[3*l+1]);
         c5_in.m[l+1][2] = u[31:0];
         c5_in.ovf       = c5_in.ovf | u[32];
         u = upd(c4_ff.r[l+1], c4_ff.pr[3*l+2], c4_ff.pn[3*l+2]);
         c5_in.r[l+1]    = u[31:0];
         c5_in.ovf       = c5_in.ovf | u[32];
      end
   end

   // step 1 cross products
   always_comb begin : s6
      c6_in       = c5_ff;
      c6_in.pr[0] = {32'd0, lsolve3_pkg::mag32(c5_ff.m[2][1])} * {32'd0, c5_ff.s[1]};
      c6_in.pr[1] = {32'd0, lsolve3_pkg::mag32(c5_ff.m[1][1])} * {32'd0, c5_ff.s[2]};
   end

   // step 1 pivot choice and swap of rows 1 and 2
   always_comb begin : s7
      logic       has;
      logic [1:0] best;
      c7_in = c6_ff;
      has   = c6_ff.m[1][1] != 32'd0;
      best  = 2'd1;
      if (c6_ff.m[2][1] != 32'd0 && (!has || c6_ff.pr[0] > c6_ff.pr[1])) begin
         has  = 1'b1;
         best = 2'd2;
      end
      if (!c6_ff.sing) begin
         c7_in.piv1 = best;
         if (!has) c7_in.sing = 1'b1;
      end
      if (best == 2'd2) begin
         c7_in.m[1] = c6_ff.m[2];  c7_in.m[2] = c6_ff.m[1];
         c7_in.r[1] = c6_ff.r[2];  c7_in.r[2] = c6_ff.r[1];
         c7_in.s[1] = c6_ff.s[2];  c7_in.s[2] = c6_ff.s[1];
      end
   end

   assign db_num[0] = c7_ff.m[2][1];
   assign db_den[0] = c7_ff.m[1][1];

   lsolve3_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .PAY_W(CTX_W)) u_div_b (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(v7_ff), .in_num(db_num), .in_den(db_den), .in_pay(c7_ff),
      .out_valid(db_valid), .out_quot(db_quot), .out_ovf(db_ovf), .out_pay(db_ctx)
   );

   // step 1 update products
   always_comb begin : s8
      c8_in       = db_ctx;
      c8_in.ovf   = db_ctx.ovf | db_ovf[0];
      c8_in.pr[0] = mulq_mag(db_quot[0], db_ctx.m[1][2]);
      c8_in.pn[0] = db_quot[0][31] ^ db_ctx.m[1][2][31];
      c8_in.pr[1] = mulq_mag(db_quot[0], db_ctx.r[1]);
      c8_in.pn[1] = db_quot[0][31] ^ db_ctx.r[1][31];
   end

   // step 1 eliminate, final pivot check
   always_comb begin : s9
      logic [32:0] u;
      c9_in         = c8_ff;
      c9_in.m[2][1] = 32'd0;
      u             = upd(c8_ff.m[2][2], c8_ff.pr[0], c8_ff.pn[0]);
      c9_in.m[2][2] = u[31:0];
      c9_in.ovf     = c8_ff.ovf | u[32];
      if (u[31:0] == 32'd0) c9_in.sing = 1'b1;
      u             = upd(c8_ff.r[2], c8_ff.pr[1], c8_ff.pn[1]);
      c9_in.r[2]    = u[31:0];
      c9_in.ovf     = c9_in.ovf | u[32];
   end

   // x2 = r2 / m22
   assign dc_num[0] = c9_ff.r[2];
   assign dc_den[0] = c9_ff.m[2][2];

   lsolve3_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .PAY_W(CTX_W)) u_div_c (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(v9_ff), .in_num(dc_num), .in_den(dc_den), .in_pay(c9_ff),
      .out_valid(dc_valid), .out_quot(dc_quot), .out_ovf(dc_ovf), .out_pay(dc_ctx)
   );

   // row 1 sum term m12 * x2
   always_comb begin : s10
      c10_in       = dc_ctx;
      c10_in.x[2]  = dc_quot[0];
      c10_in.ovf   = dc_ctx.ovf | dc_ovf[0];
      c10_in.pr[0] = mulq_mag(dc_ctx.m[1][2], dc_quot[0]);
      c10_in.pn[0] = dc_ctx.m[1][2][31] ^ dc_quot[0][31];
   end

   // saturate the row 1 sum
   always_comb begin : s11
      logic [32:0] u;
      c11_in       = c10_ff;
      u            = sat64(c10_ff.pn[0] ? 64'd0 - c10_ff.pr[0] : c10_ff.pr[0]);
      c11_in.pr[1] = {32'd0, u[31:0]};
      c11_in.ovf   = c10_ff.ovf | u[32];
   end

   // row 1 numerator r1 - sum
   always_comb begin : s12
      logic [32:0] u;
      c12_in       = c11_ff;
      u            = sat64({{32{c11_ff.r[1][31]}}, c11_ff.r[1]} -
                           {{32{c11_ff.pr[1][31]}}, c11_ff.pr[1][31:0]});
      c12_in.pr[2] = {32'd0, u[31:0]};
      c12_in.ovf   = c11_ff.ovf | u[32];
   end

   assign dd_num[0] = c12_ff.pr[2][31:0];
   assign dd_den[0] = c12_ff.m[1][1];

   lsolve3_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .PAY_W(CTX_W)) u_div_d (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(v12_ff), .in_num(dd_num), .in_den(dd_den), .in_pay(c12_ff),
      .out_valid(dd_valid), .out_quot(dd_quot), .out_ovf(dd_ovf), .out_pay(dd_ctx)
   );

   // row 0 sum terms m01 * x1 and m02 * x2
   always_comb begin : s13
      c13_in       = dd_ctx;
      c13_in.x[1]  = dd_quot[0];
      c13_in.ovf   = dd_ctx.ovf | dd_ovf[0];
      c13_in.pr[0] = mulq_mag(dd_ctx.m[0][1], dd_quot[0]);
      c13_in.pn[0] = dd_ctx.m[0][1][31] ^ dd_quot[0][31];
      c13_in.pr[1] = mulq_mag(dd_ctx.m[0][2], dd_ctx.x[2]);
      c13_in.pn[1] = dd_ctx.m[0][2][31] ^ dd_ctx.x[2][31];
   end

   // apply term signs
   always_comb begin : s14
      c14_in       = c13_ff;
      c14_in.pr[0] = c13_ff.pn[0] ? 64'd0 - c13_ff.pr[0] : c13_ff.pr[0];
      c14_in.pr[1] = c13_ff.pn[1] ? 64'd0 - c13_ff.pr[1] : c13_ff.pr[1];
   end

   // exact sum, then saturate
   always_comb begin : s15
      logic [32:0] u;
      c15_in       = c14_ff;
      u            = sat64(c14_ff.pr[0] + c14_ff.pr[1]);
      c15_in.pr[2] = {32'd0, u[31:0]};
      c15_in.ovf   = c14_ff.ovf | u[32];
   end

   // row 0 numerator r0 - sum
   always_comb begin : s16
      logic [32:0] u;
      c16_in       = c15_ff;
      u            = sat64({{32{c15_ff.r[0][31]}}, c15_ff.r[0]} -
                           {{32{c15_ff.pr[2][31]}}, c15_ff.pr[2][31:0]});
      c16_in.pr[3] = {32'd0, u[31:0]};
      c16_in.ovf   = c15_ff.ovf | u[32];
   end

   assign de_num[0] = c16_ff.pr[3][31:0];
   assign de_den[0] = c16_ff.m[0][0];

   lsolve3_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .PAY_W(CTX_W)) u_div_e (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(v16_ff), .in_num(de_num), .in_den(de_den), .in_pay(c16_ff),
      .out_valid(de_valid), .out_quot(de_quot), .out_ovf(de_ovf), .out_pay(de_ctx)
   );

   // assemble the response
   always_comb begin : result
      res.sol_0        = de_ctx.sing ? de_ctx.b[0] : de_quot[0];
      res.sol_1        = de_ctx.sing ? de_ctx.b[1] : de_ctx.x[1];
      res.sol_2        = de_ctx.sing ? de_ctx.b[2] : de_ctx.x[2];
      res.pivot_first  = de_ctx.piv0;
      res.pivot_second = de_ctx.piv1;
      if (de_ctx.sing)                  res.status = lsolve3_pkg::ST_SINGULAR;
      else if (de_ctx.ovf || de_ovf[0]) res.status = lsolve3_pkg::ST_OVERFLOW;
      else                              res.status = lsolve3_pkg::ST_OK;
   end

   // pipeline advance: held only while the output buffer is full
   assign adv       = ocnt_ff != 2'd2;
   assign req_ready = adv;
   assign push      = adv && de_valid;
   assign pop       = (ocnt_ff != 2'd0) && rsp_ready;
   assign rsp_valid = ocnt_ff != 2'd0;
   assign rsp_data  = head_ff;

   always_comb begin
      ocnt_in = ocnt_ff;
      if (push && !pop)      ocnt_in = ocnt_ff + 2'd1;
      else if (!push && pop) ocnt_in = ocnt_ff - 2'd1;
   end

   // valid bits and buffer count
   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff} <= '0;
         {v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff} <= '0;
         ocnt_ff <= 2'd0;
      end else begin
         ocnt_ff <= ocnt_in;
         if (adv) begin
            v1_ff  <= req_valid;
            v2_ff  <= v1_ff;
            v3_ff  <= v2_ff;
            v4_ff  <= da_valid;
            v5_ff  <= v4_ff;
            v6_ff  <= v5_ff;
            v7_ff  <= v6_ff;
            v8_ff  <= db_valid;
            v9_ff  <= v8_ff;
            v10_ff <= dc_valid;
            v11_ff <= v10_ff;
            v12_ff <= v11_ff;
            v13_ff <= dd_valid;
            v14_ff <= v13_ff;
            v15_ff <= v14_ff;
            v16_ff <= v15_ff;
         end
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         c3_ff  <= c3_in;
         c4_ff  <= c4_in;
         c5_ff  <= c5_in;
         c6_ff  <= c6_in;
         c7_ff  <= c7_in;
         c8_ff  <= c8_in;
         c9_ff  <= c9_in;
         c10_ff <= c10_in;
         c11_ff <= c11_in;
         c12_ff <= c12_in;
         c13_ff <= c13_in;
         c14_ff <= c14_in;
         c15_ff <= c15_in;
         c16_ff <= c16_in;
      end
   end

   // output buffer: head is shown, skid catches one more response
   always_ff @(posedge clock) begin
      if (pop && ocnt_ff == 2'd2) head_ff <= skid_ff;
      if (push) begin
         if (ocnt_ff == 2'd0 || (ocnt_ff == 2'd1 && pop)) head_ff <= res;
         else                                              skid_ff <= res;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/lsolve3_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lsolve3_div #(
   parameter int FRAC_BITS = lsolve3_pkg::FRAC_BITS_DEF,
   parameter int LANES     = 1,
   parameter int PAY_W     = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [LANES-1:0][31:0]  in_num,
   input  logic [LANES-1:0][31:0]  in_den,
   input  logic [PAY_W-1:0]        in_pay,
   output logic                    out_valid,
   output logic [LANES-1:0][31:0]  out_quot,
   output logic [LANES-1:0]        out_ovf,
   output logic [PAY_W-1:0]        out_pay
);

   localparam int NST = lsolve3_pkg::DIV_BITS / lsolve3_pkg::DIV_STEP;

   typedef struct packed {
      logic [31:0] rem;
      logic [32:0] low;
      logic [32:0] quot;
      logic [31:0] den;
      logic        neg;
      logic        big;
   } lane_type;

   lane_type [LANES-1:0] st_ff [0:NST];
   lane_type [LANES-1:0] st0_in;
   lane_type [LANES-1:0] st_in [1:NST];
   logic [PAY_W-1:0]     pay_ff [0:NST];
   logic                 vld_ff [0:NST];

   logic [LANES-1:0][31:0] quot_in, quot_ff;
   logic [LANES-1:0]       ovf_in, ovf_ff;
   logic [PAY_W-1:0]       opay_ff;
   logic                   ovld_ff;

   // prepare: magnitudes, scaled dividend, early overflow when q >= 2^33
   always_comb begin : prep
      logic [31:0] mn;
      logic [63:0] nn;
      for (int l = 0; l < LANES; l++) begin
         mn = lsolve3_pkg::mag32(in_num[l]);
         nn = {32'd0, mn} << FRAC_BITS;
         st0_in[l].den  = lsolve3_pkg::mag32(in_den[l]);
         st0_in[l].big  = {1'b0, nn[63:33]} >= st0_in[l].den;
         st0_in[l].rem  = st0_in[l].big ? 32'd0 : {1'b0, nn[63:33]};
         st0_in[l].low  = nn[32:0];
         st0_in[l].quot = '0;
         st0_in[l].neg  = in_num[l][31] ^ in_den[l][31];
      end
   end

   // restoring division, DIV_STEP quotient bits per stage
   always_comb begin : steps
      lane_type    cur;
      logic [32:0] rr;
      for (int k = 1; k <= NST; k++) begin
         for (int l = 0; l < LANES; l++) begin
            cur = st_ff[k-1][l];
            for (int t = 0; t < lsolve3_pkg::DIV_STEP; t++) begin
               rr      = {cur.rem, cur.low[32]};
               cur.low = {cur.low[31:0], 1'b0};
               if (rr >= {1'b0, cur.den}) begin
                  rr       = rr - {1'b0, cur.den};
                  cur.quot = {cur.quot[31:0], 1'b1};
               end else begin
                  cur.quot = {cur.quot[31:0], 1'b0};
               end
               cur.rem = rr[31:0];
            end
            st_in[k][l] = cur;
         end
      end
   end

   // sign and saturation
   always_comb begin : fin
      lane_type cur;
      for (int l = 0; l < LANES; l++) begin
         cur        = st_ff[NST][l];
         ovf_in[l]  = 1'b0;
         quot_in[l] = cur.quot[31:0];
         if (cur.big) begin
            ovf_in[l]  = 1'b1;
            quot_in[l] = cur.neg ? 32'h8000_0000 : 32'h7fff_ffff;
         end else if (cur.neg) begin
            if (cur.quot > 33'h0_8000_0000) begin
               ovf_in[l]  = 1'b1;
               quot_in[l] = 32'h8000_0000;
            end else begin
               quot_in[l] = 32'd0 - cur.quot[31:0];
            end
         end else if (cur.quot[32] || cur.quot[31]) begin
            ovf_in[l]  = 1'b1;
            quot_in[l] = 32'h7fff_ffff;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NST; k++) vld_ff[k] <= 1'b0;
         ovld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= NST; k++) vld_ff[k] <= vld_ff[k-1];
         ovld_ff <= vld_ff[NST];
      end
   end

   // data
   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff[0] <= st0_in;
         for (int k = 1; k <= NST; k++) st_ff[k] <= st_in[k];
         pay_ff[0] <= in_pay;
         for (int k = 1; k <= NST; k++) pay_ff[k] <= pay_ff[k-1];
         quot_ff <= quot_in;
         ovf_ff  <= ovf_in;
         opay_ff <= pay_ff[NST];
      end
   end

   assign out_valid = ovld_ff;
   assign out_quot  = quot_ff;
   assign out_ovf   = ovf_ff;
   assign out_pay   = opay_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int  FRAC      = lsolve3_pkg::FRAC_BITS_DEF;
   localparam int  ONE       = 1 << FRAC;
   localparam int  WD_LIMIT  = 5000;
   localparam int  HOLD_LEN  = 300;
   localparam int  TAIL_WAIT = 120;
   localparam int  N_RANDOM  = 1330;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   lsolve3_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   lsolve3_pkg::rsp_type rsp_data;

   // one row of the directed table
   typedef struct {
      lsolve3_pkg::req_type q;
      bit                   typed;
      lsolve3_pkg::rsp_type r;
   } dir_row_type;

   dir_row_type          dir_rows[$];
   lsolve3_pkg::rsp_type sol_pending[$];
   int       mismatches;
   int       send_idle_pct;
   int       recv_idle_pct;
   bit       hold_request;
   int       n_sent;
   int       n_got;
   int       n_singular;
   int       n_overflow;
   int       quiet_cycles;

   linear_solve_3x3_scaled_pivot uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------- solver prediction ----------------

   function automatic longint unsigned absval(longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint clamp32(longint v, inout bit of);
      if (v > 64'sd2147483647) begin
         of = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         of = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // product truncated toward zero
   function automatic longint qmul(longint a, longint b);
      longint unsigned p;
      p = (absval(a) * absval(b)) >> FRAC;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // quotient truncated toward zero, saturated
   function automatic longint qdiv(longint n, longint d, inout bit of);
      longint unsigned qt;
      qt = (absval(n) << FRAC) / absval(d);
      if ((n < 0) != (d < 0)) begin
         if (qt > 64'h8000_0000) begin
            of = 1'b1;
            return -64'sd2147483648;
         end
         return -longint'(qt);
      end
      if (qt > 64'h7fff_ffff) begin
         of = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(qt);
   endfunction

   function automatic lsolve3_pkg::rsp_type solve_predict(lsolve3_pkg::req_type q);
      longint               m[3][3];
      longint               r[3];
      longint               b[3];
      longint               x[3];
      longint unsigned      s[3];
      longint unsigned      am, bmag;
      longint               t, mult, sum, num;
      int                   piv[2];
      int                   best;
      bit                   sing, of;
      lsolve3_pkg::rsp_type res;
      m[0][0] = q.a_00; m[0][1] = q.a_01; m[0][2] = q.a_02;
      m[1][0] = q.a_10; m[1][1] = q.a_11; m[1][2] = q.a_12;
      m[2][0] = q.a_20; m[2][1] = q.a_21; m[2][2] = q.a_22;
      b[0] = q.rhs_0; b[1] = q.rhs_1; b[2] = q.rhs_2;
      piv[0] = 0;
      piv[1] = 1;
      sing = 1'b0;
      of = 1'b0;
      // row scales and zero rows
      for (int i = 0; i < 3; i++) begin
         r[i] = b[i];
         s[i] = 0;
         for (int j = 0; j < 3; j++)
            if (absval(m[i][j]) > s[i]) s[i] = absval(m[i][j]);
         if (s[i] == 0) sing = 1'b1;
      end
      // elimination with scaled pivot choice
      for (int k = 0; k < 2; k++) begin
         if (!sing) begin
            best = -1;
            bmag = 0;
            for (int i = k; i < 3; i++) begin
               am = absval(m[i][k]);
               if (am != 0 && (best < 0 || am * s[best] > bmag * s[i])) begin
                  best = i;
                  bmag = am;
               end
            end
            if (best < 0) begin
               sing = 1'b1;
            end else begin
               piv[k] = best;
               if (best != k) begin
                  for (int j = 0; j < 3; j++) begin
                     t = m[k][j]; m[k][j] = m[best][j]; m[best][j] = t;
                  end
                  t = r[k]; r[k] = r[best]; r[best] = t;
                  am = s[k]; s[k] = s[best]; s[best] = am;
               end
               for (int i = k + 1; i < 3; i++) begin
                  mult = qdiv(m[i][k], m[k][k], of);
                  m[i][k] = 0;
                  for (int j = k + 1; j < 3; j++)
                     m[i][j] = clamp32(m[i][j] - qmul(mult, m[k][j]), of);
                  r[i] = clamp32(r[i] - qmul(mult, r[k]), of);
               end
            end
         end
      end
      if (!sing && m[2][2] == 0) sing = 1'b1;
      // back substitution
      if (sing) begin
         for (int i = 0; i < 3; i++) x[i] = b[i];
      end else begin
         for (int i = 2; i >= 0; i--) begin
            sum = 0;
            for (int j = i + 1; j < 3; j++) sum += qmul(m[i][j], x[j]);
            sum = clamp32(sum, of);
            num = clamp32(r[i] - sum, of);
            x[i] = qdiv(num, m[i][i], of);
         end
      end
      res.sol_0 = x[0][31:0];
      res.sol_1 = x[1][31:0];
      res.sol_2 = x[2][31:0];
      res.pivot_first = piv[0][1:0];
      res.pivot_second = piv[1][1:0];
      res.status = sing ? lsolve3_pkg::ST_SINGULAR :
                   (of ? lsolve3_pkg::ST_OVERFLOW : lsolve3_pkg::ST_OK);
      return res;
   endfunction

   // ---------------- stimulus ----------------

   function automatic lsolve3_pkg::req_type mk_req(int a00, int a01, int a02, int a10,
                                                   int a11, int a12, int a20, int a21,
                                                   int a22, int r0, int r1, int r2);
      lsolve3_pkg::req_type q;
      q.a_00 = a00; q.a_01 = a01; q.a_02 = a02;
      q.a_10 = a10; q.a_11 = a11; q.a_12 = a12;
      q.a_20 = a20; q.a_21 = a21; q.a_22 = a22;
      q.rhs_0 = r0; q.rhs_1 = r1; q.rhs_2 = r2;
      return q;
   endfunction

   function automatic lsolve3_pkg::rsp_type mk_rsp(int x0, int x1, int x2, logic [1:0] p0,
                                                   logic [1:0] p1, logic [1:0] st);
      lsolve3_pkg::rsp_type r;
      r.sol_0 = x0; r.sol_1 = x1; r.sol_2 = x2;
      r.pivot_first = p0; r.pivot_second = p1; r.status = st;
      return r;
   endfunction

   function automatic void add_row(lsolve3_pkg::req_type q, bit typed,
                                   lsolve3_pkg::rsp_type r);
      dir_row_type d;
      d.q = q;
      d.typed = typed;
      d.r = r;
      dir_rows.push_back(d);
   endfunction

   function automatic int rnd_span(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // random system, mostly well formed, some degenerate or extreme
   function automatic lsolve3_pkg::req_type rnd_req();
      lsolve3_pkg::req_type q;
      int      w[12];
      int      mode;
      mode = $urandom_range(99);
      for (int i = 0; i < 12; i++) begin
         if (mode < 55)       w[i] = rnd_span(4 * ONE);
         else if (mode < 72)  w[i] = $urandom;
         else if (mode < 84)  w[i] = ($urandom_range(1) == 0) ? 0 : rnd_span(3) * ONE;
         else if (mode < 92)  w[i] = rnd_span(2 * ONE);
         else                 w[i] = rnd_span(8);
      end
      if (mode < 55) begin
         // strengthen the diagonal now and then
         if ($urandom_range(1) == 0) begin
            w[0] += 6 * ONE; w[4] -= 6 * ONE; w[8] += 6 * ONE;
         end
         w[9] = rnd_span(16 * ONE);
      end else if (mode >= 84 && mode < 92) begin
         // rank deficient: a repeated row or an empty column
         case ($urandom_range(2))
            0: begin w[6] = w[0]; w[7] = w[1]; w[8] = w[2]; end
            1: begin w[3] = w[0]; w[4] = w[1]; w[5] = w[2]; end
            default: begin w[0] = 0; w[3] = 0; w[6] = 0; end
         endcase
      end else if (mode >= 92) begin
         // tiny matrix, large right-hand side: saturates
         w[9] = $urandom; w[10] = $urandom; w[11] = $urandom;
      end
      q = mk_req(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8],
                 w[9], w[10], w[11]);
      return q;
   endfunction

   // offer one request, wait for acceptance, record its expected solution
   task automatic send_req(lsolve3_pkg::req_type q, bit typed, lsolve3_pkg::rsp_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sol_pending.push_back(typed ? r : solve_predict(q));
      n_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sol_pending.size() != 0) @(posedge clock);
   endtask

   // ---------------- response check ----------------

   task automatic cmp_field(string nm, longint e, longint a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, nm, e, a);
         mismatches++;
      end
   endtask

   initial begin
      lsolve3_pkg::rsp_type e;
      int                   hold_cnt;
      bit                   hold_done;
      hold_cnt = 0;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            n_got++;
            if (sol_pending.size() == 0) begin
               $display("%0t: unexpected response, expected none got %h", $time, rsp_data);
               mismatches++;
            end else begin
               e = sol_pending.pop_front();
               cmp_field("sol_0", e.sol_0, rsp_data.sol_0);
               cmp_field("sol_1", e.sol_1, rsp_data.sol_1);
               cmp_field("sol_2", e.sol_2, rsp_data.sol_2);
               cmp_field("pivot_first", e.pivot_first, rsp_data.pivot_first);
               cmp_field("pivot_second", e.pivot_second, rsp_data.pivot_second);
               cmp_field("status", e.status, rsp_data.status);
               if (e.status == lsolve3_pkg::ST_SINGULAR) n_singular++;
               if (e.status == lsolve3_pkg::ST_OVERFLOW) n_overflow++;
            end
         end
         // long hold-off so the pipeline backs up into the input
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt = HOLD_LEN;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      lsolve3_pkg::rsp_type z;
      z = '0;
      n_sent = 0;
      hold_request = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 51;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table: all zero, identity, zero row, zero columns, zero final pivot, row swap
      add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_rsp(0, 0, 0, 2'd0, 2'd1, lsolve3_pkg::ST_SINGULAR));
      add_row(mk_req(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 2 * ONE, -3 * ONE), 1,
              mk_rsp(ONE, 2 * ONE, -3 * ONE, 2'd0, 2'd1, lsolve3_pkg::ST_OK));
      add_row(mk_req(ONE, 2, 3, 4, ONE, 6, 0, 0, 0, 5, 6, 7), 1,
              mk_rsp(5, 6, 7, 2'd0, 2'd1, lsolve3_pkg::ST_SINGULAR));
      add_row(mk_req(0, ONE, 2, 0, 3, ONE, 0, 5, 7, -1, -2, -3), 1,
              mk_rsp(-1, -2, -3, 2'd0, 2'd1, lsolve3_pkg::ST_SINGULAR));
      add_row(mk_req(ONE, 0, 0, ONE, 0, ONE, ONE, 0, 2 * ONE, 9, 8, 7), 1,
              mk_rsp(9, 8, 7, 2'd0, 2'd1, lsolve3_pkg::ST_SINGULAR));
      add_row(mk_req(ONE, 0, 0, 0, ONE, 0, 0, ONE, 0, 1, 2, 3), 1,
              mk_rsp(1, 2, 3, 2'd0, 2'd1, lsolve3_pkg::ST_SINGULAR));
      add_row(mk_req(ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0), 0, z);
      // extremes of the word
      add_row(mk_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, z);
      add_row(mk_req(32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0, z);
      add_row(mk_req(1, 0, 0, 0, -1, 0, 0, 0, 1, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000), 0, z);
      add_row(mk_req(32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 32'h8000_0000, 32'h7fff_ffff,
                     -1, 1, 32'h7fff_ffff, -1, 1, 32'hffff_ffff), 0, z);
      // pivot on lower rows, scaling changes the choice
      add_row(mk_req(ONE, 100 * ONE, 0, 2 * ONE, ONE, 0, 3 * ONE, 0, ONE, ONE, ONE, ONE), 0, z);
      add_row(mk_req(ONE, 0, 2 * ONE, 0, 0, ONE, 4 * ONE, ONE, 0, 3 * ONE, -ONE, 5 * ONE), 0, z);
      add_row(mk_req(2 * ONE, ONE, ONE, 4 * ONE, 3 * ONE, 3 * ONE, 8 * ONE, 7 * ONE, 9 * ONE,
                     ONE, 2 * ONE, 3 * ONE), 0, z);
      add_row(mk_req(-ONE, 2 * ONE, -3 * ONE, 4 * ONE, -5 * ONE, 6 * ONE, -7 * ONE,
                     8 * ONE, -10 * ONE, -ONE, -ONE, -ONE), 0, z);
      add_row(mk_req(3, 5, 7, 11, 13, 17, 19, 23, 29, 32'h4000_0000, -32'h4000_0000, 1),
              0, z);

      foreach (dir_rows[i]) send_req(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].r);
      drain();

      // three idling phases, random systems
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
         recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            if (ph == 2 && n == 50) hold_request = 1'b1;
            send_req(rnd_req(), 0, z);
         end
         drain();
      end

      repeat (TAIL_WAIT) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses (%0d singular, %0d overflow).",
               n_sent, n_got, n_singular, n_overflow);
      $display("Idling on both sides, a long output hold-off and drained pauses covered.");
      if (mismatches == 0 && sol_pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
